// ===== hdl/btb_two_level_branch_predictor_defines.svh =====
// Assertion macros shared by the branch predictor RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef BTB_TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
`define BTB_TWO_LEVEL_BRANCH_PREDICTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BTB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BTB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BTB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/btbp_pkg.sv =====
// Package for the branch predictor: payload and configuration types, codes, constants.
// Used by every module of the block except btbp_ram; depends on nothing.
package btbp_pkg;

    localparam int DEF_MAX_ENTRIES = 32;
    localparam int DEF_MAX_HISTORY = 8;
    localparam int TAG_W           = 30;
    localparam int CFG_DATA_W      = 5;
    localparam int SHARE_LO_BIT    = 2;
    localparam int SHARE_HI_BIT    = 16;
    localparam logic [31:0] PC_STEP   = 32'd4;
    localparam logic [1:0]  CTR_RESET = 2'd1;
    localparam logic [1:0]  CTR_MAX   = 2'd3;
    localparam logic [1:0]  CTR_TAKEN = 2'd2;
    localparam logic        OP_PREDICT = 1'b0;
    localparam logic        OP_UPDATE  = 1'b1;
    localparam logic [1:0]  SHARE_NONE = 2'd0;
    localparam logic [1:0]  SHARE_PC2  = 2'd1;
    localparam logic [1:0]  SHARE_PC16 = 2'd2;

    typedef enum logic [2:0] {
        CFG_LOG2_ENTRIES = 3'd0,
        CFG_HISTORY_BITS = 3'd1,
        CFG_TAG_BITS     = 3'd2,
        CFG_COUNTER_INIT = 3'd3,
        CFG_GLOBAL_HIST  = 3'd4,
        CFG_GLOBAL_TABLE = 3'd5,
        CFG_SHARE_MODE   = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FILL,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic        operation;
        logic [31:0] pc;
        logic [31:0] actual_target;
        logic        actual_taken;
        logic [31:0] prior_prediction;
    } t_in;

    typedef struct packed {
        logic        predicted_taken;
        logic [31:0] predicted_target;
        logic        mispredicted;
        logic [31:0] branch_count;
        logic [31:0] flush_count;
    } t_out;

    typedef struct packed {
        logic [2:0] log2_entries;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] counter_init;
        logic       use_global_history;
        logic       use_global_table;
        logic [1:0] share_mode;
    } t_cfg;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_ctrl;

endpackage

// ===== hdl/btbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the counter tables; depends on nothing.
module btbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/btbp_front.sv =====
// Front end: accepts transactions into a two-entry queue for the back end.
// Depends on btbp_pkg.
module btbp_front
    import btbp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_in     i_in,
    output t_q_ctrl o_q_ctrl_valid,
    input  logic    i_pop,
    output t_in     o_q_item
);
    t_in        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push = i_in_valid && !o_in_stall;
    assign o_q_ctrl_valid.valid = (r_cnt != 2'd0);
    assign o_q_ctrl_valid.pop = i_pop && (r_cnt != 2'd0);
    assign o_q_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (o_q_ctrl_valid.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(o_q_ctrl_valid.pop);
        end
    end
endmodule

// ===== hdl/btbp_back.sv =====
// Back end: buffer lookup, counter tables, allocation fill and result register.
// Depends on btbp_pkg, btbp_ram and the assertion macro header.
`include "btb_two_level_branch_predictor_defines.svh"
module btbp_back
    import btbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_HISTORY = DEF_MAX_HISTORY
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_q_ctrl i_q_ctrl,
    input  t_in     i_q_item,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_out    o_out
);
    localparam int LOG2_MAX = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int IDX_W    = (LOG2_MAX > 0) ? LOG2_MAX : 1;
    localparam int NUM_ENT  = 1 << IDX_W;
    localparam int HIST_W   = MAX_HISTORY;
    localparam int CADDR_W  = IDX_W + HIST_W;

    t_state r_state, n_state;
    t_in    r_item;
    logic   r_valid [NUM_ENT];
    logic [TAG_W-1:0]  r_tag    [NUM_ENT];
    logic [31:0]       r_target [NUM_ENT];
    logic [HIST_W-1:0] r_ehist  [NUM_ENT];
    logic [HIST_W-1:0] r_shist;
    logic [31:0]       r_upd, r_flush;
    logic [HIST_W-1:0] r_fill;
    logic [CADDR_W-1:0] r_clr;
    logic   r_out_valid;
    t_out   r_out;

    logic [2:0] eff_l;
    logic [3:0] eff_h;
    logic [4:0] tag_max, eff_t;
    logic [IDX_W-1:0]  idx_mask, idx;
    logic [HIST_W-1:0] hmask, hist, hm, hx, new_hist, fill_last;
    logic [TAG_W-1:0]  tmask, tag;
    logic [31:0] shifted;
    logic hit, is_upd, misp, out_free, alloc, out_load;
    logic [1:0] e_rd, s_rd, ctr, ctr_next;
    logic e_we, s_we;
    logic [CADDR_W-1:0] e_waddr, e_raddr;
    logic [HIST_W-1:0]  s_waddr;
    logic [1:0] e_wdata, s_wdata;

    always_comb begin
        eff_l = (32'(i_cfg.log2_entries) > LOG2_MAX) ? 3'(LOG2_MAX) : i_cfg.log2_entries;
        if (i_cfg.history_bits == 4'd0) begin
            eff_h = 4'd1;
        end else if (32'(i_cfg.history_bits) > MAX_HISTORY) begin
            eff_h = 4'(MAX_HISTORY);
        end else begin
            eff_h = i_cfg.history_bits;
        end
        tag_max = 5'(TAG_W) - {2'b00, eff_l};
        eff_t = (i_cfg.tag_bits > tag_max) ? tag_max : i_cfg.tag_bits;
        for (int i = 0; i < IDX_W; i++) begin
            idx_mask[i] = (i < 32'(eff_l));
        end
        for (int i = 0; i < HIST_W; i++) begin
            hmask[i] = (i < 32'(eff_h));
            fill_last[i] = 1'b1;
        end
        for (int i = 0; i < TAG_W; i++) begin
            tmask[i] = (i < 32'(eff_t));
        end
        idx = r_item.pc[2 +: IDX_W] & idx_mask;
        shifted = r_item.pc >> ({3'b000, eff_l} + 6'd2);
        tag = shifted[TAG_W-1:0] & tmask;
        hit = r_valid[idx] && (r_tag[idx] == tag);
        is_upd = (r_item.operation == OP_UPDATE);
        hist = i_cfg.use_global_history ? r_shist : r_ehist[idx];
        hm = hist & hmask;
        case (i_cfg.share_mode)
            SHARE_PC2:  hx = hm ^ (r_item.pc[SHARE_LO_BIT +: HIST_W] & hmask);
            SHARE_PC16: hx = hm ^ (r_item.pc[SHARE_HI_BIT +: HIST_W] & hmask);
            default:    hx = hm;
        endcase
        e_raddr = {idx, hm};
        ctr = i_cfg.use_global_table ? s_rd : e_rd;
        if (r_item.actual_taken) begin
            ctr_next = (ctr == CTR_MAX) ? ctr : ctr + 2'd1;
        end else begin
            ctr_next = (ctr == 2'd0) ? ctr : ctr - 2'd1;
        end
        new_hist = ((hist << 1) | HIST_W'(r_item.actual_taken)) & hmask;
        misp = r_item.actual_taken ? (r_item.actual_target != r_item.prior_prediction)
                                   : ((r_item.pc + PC_STEP) != r_item.prior_prediction);
        out_free = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (&r_clr) n_state = ST_IDLE;
            ST_IDLE:   if (i_q_ctrl.valid) n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = (is_upd && !hit) ? ST_FILL : ST_EXEC;
            ST_FILL:   if (r_fill == fill_last) n_state = ST_LOOKUP;
            ST_EXEC:   if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        alloc    = 1'b0;
        out_load = 1'b0;
        e_we     = 1'b0;
        s_we     = 1'b0;
        e_waddr  = {idx, r_fill};
        e_wdata  = i_cfg.counter_init;
        s_waddr  = hx;
        s_wdata  = ctr_next;
        unique case (r_state)
            ST_CLEAR: begin
                e_we    = 1'b1;
                s_we    = 1'b1;
                e_waddr = r_clr;
                e_wdata = CTR_RESET;
                s_waddr = r_clr[HIST_W-1:0];
                s_wdata = CTR_RESET;
            end
            ST_IDLE: begin
                o_pop = i_q_ctrl.valid;
            end
            ST_LOOKUP: begin
                alloc = is_upd && !hit;
            end
            ST_FILL: begin
                e_we = 1'b1;
            end
            ST_EXEC: begin
                out_load = out_free;
                if (out_free && is_upd) begin
                    e_we    = !i_cfg.use_global_table;
                    s_we    = i_cfg.use_global_table;
                    e_waddr = e_raddr;
                    e_wdata = ctr_next;
                end
            end
            default: begin
            end
        endcase
    end

    btbp_ram #(.WIDTH(2), .DEPTH(1 << CADDR_W)) u_entry_ctr (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rd)
    );

    btbp_ram #(.WIDTH(2), .DEPTH(1 << HIST_W)) u_shared_ctr (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (hx),
        .o_rdata (s_rd)
    );

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_q_item;
        end
        if (alloc) begin
            r_tag[idx] <= tag;
        end
        if (out_load && is_upd) begin
            r_target[idx] <= r_item.actual_target;
        end
        if (out_load) begin
            r_out.predicted_taken  <= !is_upd && hit && (ctr >= CTR_TAKEN);
            r_out.predicted_target <= is_upd ? 32'd0 :
                (hit && (ctr >= CTR_TAKEN)) ? r_target[idx] : r_item.pc + PC_STEP;
            r_out.mispredicted     <= is_upd && misp;
            r_out.branch_count     <= is_upd ? r_upd + 32'd1 : r_upd;
            r_out.flush_count      <= (is_upd && misp) ? r_flush + 32'd1 : r_flush;
        end
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_fill      <= '0;
            r_shist     <= '0;
            r_upd       <= '0;
            r_flush     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_ENT; i++) begin
                r_valid[i] <= 1'b0;
                r_ehist[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (alloc) begin
                r_valid[idx] <= 1'b1;
                r_ehist[idx] <= '0;
                r_fill       <= '0;
            end else if (r_state == ST_FILL) begin
                r_fill <= r_fill + 1'b1;
            end
            if (out_load && is_upd) begin
                r_upd <= r_upd + 32'd1;
                if (misp) begin
                    r_flush <= r_flush + 32'd1;
                end
                if (i_cfg.use_global_history) begin
                    r_shist <= new_hist;
                end else begin
                    r_ehist[idx] <= new_hist;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

    `BTB_ASSERT_SAME(a_pop_only_idle, i_clk, i_rst_n, o_pop, r_state == ST_IDLE)
    `BTB_ASSERT_NEXT(a_pop_to_lookup, i_clk, i_rst_n, o_pop, r_state == ST_LOOKUP)
    `BTB_ASSERT_NEXT(a_alloc_hits, i_clk, i_rst_n, alloc, r_state == ST_FILL && r_fill == '0)
    `BTB_ASSERT_NEXT(a_held_result, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid)
endmodule

// ===== hdl/btb_two_level_branch_predictor.sv =====
// Sequence: the back end pops an accepted transaction in IDLE, looks it up in LOOKUP, and
// registers the result and writes back the counter in EXEC, where it waits while a held result
// is stalled; an update that misses passes through FILL to refill the entry's counter row and
// then looks it up again. The back end takes a new transaction only once the last has left
// EXEC; the front queue holds two transactions. Reset: synchronous, active low; afterwards
// the counter RAMs are swept with the reset counter value before the first transaction.
module btb_two_level_branch_predictor
    import btbp_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_HISTORY = DEF_MAX_HISTORY
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cfg    r_cfg;
    t_q_ctrl q_ctrl;
    t_in     q_item;
    logic    pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.log2_entries       <= 3'd5;
            r_cfg.history_bits       <= 4'd8;
            r_cfg.tag_bits           <= 5'd0;
            r_cfg.counter_init       <= CTR_RESET;
            r_cfg.use_global_history <= 1'b0;
            r_cfg.use_global_table   <= 1'b0;
            r_cfg.share_mode         <= SHARE_NONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LOG2_ENTRIES: r_cfg.log2_entries       <= i_cfg_data[2:0];
                CFG_HISTORY_BITS: r_cfg.history_bits       <= i_cfg_data[3:0];
                CFG_TAG_BITS:     r_cfg.tag_bits           <= i_cfg_data[4:0];
                CFG_COUNTER_INIT: r_cfg.counter_init       <= i_cfg_data[1:0];
                CFG_GLOBAL_HIST:  r_cfg.use_global_history <= i_cfg_data[0];
                CFG_GLOBAL_TABLE: r_cfg.use_global_table   <= i_cfg_data[0];
                CFG_SHARE_MODE:   r_cfg.share_mode         <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    btbp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in           (i_in),
        .o_q_ctrl_valid (q_ctrl),
        .i_pop          (pop),
        .o_q_item       (q_item)
    );

    btbp_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_ctrl    (q_ctrl),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );
endmodule
